// ===== hdl/ctok_pkg.sv =====
// Shared types, widths, token kinds and keyword table of the source tokenizer.
`timescale 1ns / 1ps

package ctok_pkg;

  // Field widths
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 16;
  localparam int OFFSET_BITS = 24;
  localparam int LEN_BITS    = 16;
  localparam int KIND_BITS   = 6;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;

  // Token kinds
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd0;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd1;
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd2;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd3;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 6'd4;
  localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd5;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd6;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd7;
  localparam logic [KIND_BITS-1:0] K_STAR    = 6'd8;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd9;
  localparam logic [KIND_BITS-1:0] K_PERCENT = 6'd10;
  localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd11;
  localparam logic [KIND_BITS-1:0] K_EQ      = 6'd12;
  localparam logic [KIND_BITS-1:0] K_BANG    = 6'd13;
  localparam logic [KIND_BITS-1:0] K_NE      = 6'd14;
  localparam logic [KIND_BITS-1:0] K_LT      = 6'd15;
  localparam logic [KIND_BITS-1:0] K_LE      = 6'd16;
  localparam logic [KIND_BITS-1:0] K_GT      = 6'd17;
  localparam logic [KIND_BITS-1:0] K_GE      = 6'd18;
  localparam logic [KIND_BITS-1:0] K_AND     = 6'd19;
  localparam logic [KIND_BITS-1:0] K_OR      = 6'd20;
  localparam logic [KIND_BITS-1:0] K_INT     = 6'd21;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd22;
  localparam int                   K_KW0     = 23;
  localparam logic [KIND_BITS-1:0] K_ERR     = 6'd40;
  localparam logic [KIND_BITS-1:0] K_EOF     = 6'd41;

  // Input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Keyword table: text right-justified, first character in the highest used byte
  localparam int KW_COUNT   = 17;
  localparam int KW_MAX_LEN = 12;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;

  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    96'("uint8"), 96'("void"), 96'("if"), 96'("else"), 96'("while"), 96'("for"),
    96'("break"), 96'("continue"), 96'("sprite"), 96'("return"),
    96'({"draw_", "sprite"}), 96'({"clear_", "screen"}), 96'({"set_", "delay"}),
    96'({"get_", "delay"}), 96'({"set_", "sound"}), 96'({"wait_", "key"}),
    96'("get_key")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd8, 4'd6, 4'd6,
    4'd11, 4'd12, 4'd9, 4'd9, 4'd9, 4'd8, 4'd7
  };

  // One token as it leaves the block
  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off;
    logic [LEN_BITS-1:0]    len;
    logic [7:0]             bad;
    logic                   last;
  } tok_t;

  // Up to two tokens produced by one request, in order a then b
  typedef struct packed {
    logic a_vld;
    tok_t a;
    logic b_vld;
    tok_t b;
  } push_t;

endpackage

// ===== hdl/ctok_lexer.sv =====
// Scan state registers and the per-byte token logic of the tokenizer.
`timescale 1ns / 1ps

module ctok_lexer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic            opcode,
  input  logic [7:0]      chr,
  output ctok_pkg::push_t push
);
  import ctok_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_SLASH, M_COMMENT, M_ZERO, M_DEC, M_HEX, M_IDENT
  } mode_t;

  mode_t                  mode_r,  mode_nxt;
  logic [7:0]             pend_r,  pend_nxt;
  logic [KW_COUNT-1:0]    cand_r,  cand_nxt;
  logic [LINE_BITS-1:0]   line_r,  line_nxt;
  logic [COLUMN_BITS-1:0] col_r,   col_nxt;
  logic [OFFSET_BITS-1:0] off_r,   off_nxt;
  logic [LINE_BITS-1:0]   sline_r, sline_nxt;
  logic [COLUMN_BITS-1:0] scol_r,  scol_nxt;
  logic [OFFSET_BITS-1:0] soff_r,  soff_nxt;
  logic [LEN_BITS-1:0]    len_r,   len_nxt;

  // Drop keywords whose character at pos differs from c
  function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] cand,
                                                 input logic [7:0] c,
                                                 input logic [LEN_BITS-1:0] pos);
    logic [KW_COUNT-1:0] res;
    logic [3:0]          idx;
    res = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      idx = KW_LEN[k] - 4'd1 - pos[3:0];
      if (pos >= LEN_BITS'(KW_LEN[k])) begin
        res[k] = 1'b0;
      end else if (KW_TEXT[k][{idx, 3'b000} +: 8] != c) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  // Kind of the token that is open now, were it closed
  logic                 close_has;
  logic [KIND_BITS-1:0] close_kind;
  logic [7:0]           close_bad;
  tok_t                 close_tok;

  always_comb begin
    close_has  = 1'b1;
    close_kind = K_INT;
    close_bad  = 8'd0;
    case (mode_r)
      M_OP: begin
        case (pend_r)
          "=":     close_kind = K_ASSIGN;
          "!":     close_kind = K_BANG;
          "<":     close_kind = K_LT;
          ">":     close_kind = K_GT;
          default: begin
            close_kind = K_ERR;
            close_bad  = pend_r;
          end
        endcase
      end
      M_SLASH: close_kind = K_SLASH;
      M_ZERO, M_DEC, M_HEX: close_kind = K_INT;
      M_IDENT: begin
        close_kind = K_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
          if (cand_r[k] && len_r == LEN_BITS'(KW_LEN[k])) begin
            close_kind = KIND_BITS'(K_KW0 + k);
          end
        end
      end
      default: close_has = 1'b0;
    endcase
    close_tok = '{kind: close_kind, line: sline_r, col: scol_r, off: soff_r,
                  len: len_r, bad: close_bad, last: 1'b0};
  end

  // Two-character operator formed by the pending byte and this one
  logic                 pair_vld;
  logic [KIND_BITS-1:0] pair_kind;

  always_comb begin
    pair_vld  = 1'b1;
    pair_kind = K_EQ;
    if      (chr == "=" && pend_r == "=") pair_kind = K_EQ;
    else if (chr == "=" && pend_r == "!") pair_kind = K_NE;
    else if (chr == "=" && pend_r == "<") pair_kind = K_LE;
    else if (chr == "=" && pend_r == ">") pair_kind = K_GE;
    else if (chr == "&" && pend_r == "&") pair_kind = K_AND;
    else if (chr == "|" && pend_r == "|") pair_kind = K_OR;
    else pair_vld = 1'b0;
  end

  // Single-character tokens
  logic                 single_vld;
  logic [KIND_BITS-1:0] single_kind;

  always_comb begin
    single_vld = 1'b1;
    case (chr)
      "{":     single_kind = K_LBRACE;
      "}":     single_kind = K_RBRACE;
      "(":     single_kind = K_LPAREN;
      ")":     single_kind = K_RPAREN;
      ",":     single_kind = K_COMMA;
      ";":     single_kind = K_SEMI;
      "+":     single_kind = K_PLUS;
      "-":     single_kind = K_MINUS;
      "*":     single_kind = K_STAR;
      "%":     single_kind = K_PERCENT;
      default: begin
        single_vld  = 1'b0;
        single_kind = K_ERR;
      end
    endcase
  end

  logic [LEN_BITS-1:0] len_grow;
  assign len_grow = (len_r == LEN_MAX) ? len_r : len_r + LEN_BITS'(1);

  // Next state and tokens for one request
  logic do_close, fresh, adv;

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    cand_nxt  = cand_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    off_nxt   = off_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    soff_nxt  = soff_r;
    len_nxt   = len_r;
    push      = '0;
    do_close  = 1'b0;
    fresh     = 1'b0;
    adv       = 1'b0;

    if (go) begin
      if (opcode == OP_END) begin
        // close anything open, then end of file; all state back to reset
        push.a_vld = close_has;
        push.a     = close_tok;
        push.b_vld = 1'b1;
        push.b     = '{kind: K_EOF, line: line_r, col: col_r, off: off_r,
                       len: '0, bad: 8'd0, last: 1'b0};
        mode_nxt  = M_IDLE;
        pend_nxt  = 8'd0;
        cand_nxt  = KW_ALL;
        line_nxt  = LINE_BITS'(1);
        col_nxt   = COLUMN_BITS'(1);
        off_nxt   = '0;
        sline_nxt = LINE_BITS'(1);
        scol_nxt  = COLUMN_BITS'(1);
        soff_nxt  = '0;
        len_nxt   = '0;
      end else begin
        // continue or close the open token
        case (mode_r)
          M_OP: begin
            if (pair_vld) begin
              push.a_vld = 1'b1;
              push.a     = '{kind: pair_kind, line: sline_r, col: scol_r, off: soff_r,
                             len: LEN_BITS'(2), bad: 8'd0, last: 1'b0};
              mode_nxt   = M_IDLE;
              pend_nxt   = 8'd0;
              len_nxt    = '0;
              adv        = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_SLASH: begin
            if (chr == "/") begin
              mode_nxt = M_COMMENT;
              len_nxt  = '0;
              adv      = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_COMMENT: begin
            if (chr != 8'h0A) begin
              adv = 1'b1;
            end else begin
              mode_nxt = M_IDLE;
              fresh    = 1'b1;
            end
          end
          M_ZERO: begin
            if (chr == "x") begin
              mode_nxt = M_HEX;
              len_nxt  = len_grow;
              adv      = 1'b1;
            end else if (is_digit(chr)) begin
              mode_nxt = M_DEC;
              len_nxt  = len_grow;
              adv      = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_DEC: begin
            if (is_digit(chr)) begin
              len_nxt = len_grow;
              adv     = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_HEX: begin
            if (is_xdigit(chr)) begin
              len_nxt = len_grow;
              adv     = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(chr) || is_digit(chr) || chr == "_") begin
              cand_nxt = narrow(cand_r, chr, len_r);
              len_nxt  = len_grow;
              adv      = 1'b1;
            end else begin
              do_close = 1'b1;
            end
          end
          default: begin
            mode_nxt = M_IDLE;
            fresh    = 1'b1;
          end
        endcase

        if (do_close) begin
          push.a_vld = 1'b1;
          push.a     = close_tok;
          mode_nxt   = M_IDLE;
          pend_nxt   = 8'd0;
          cand_nxt   = KW_ALL;
          len_nxt    = '0;
          fresh      = 1'b1;
        end

        // the byte starts something new
        if (fresh) begin
          adv = 1'b1;
          if (chr == " " || chr == 8'h09 || chr == 8'h0D || chr == 8'h0A) begin
            // whitespace
          end else if (single_vld) begin
            push.b_vld = 1'b1;
            push.b     = '{kind: single_kind, line: line_r, col: col_r, off: off_r,
                           len: LEN_BITS'(1), bad: 8'd0, last: 1'b0};
          end else if (chr == "=" || chr == "!" || chr == "<" || chr == ">" ||
                       chr == "&" || chr == "|" || chr == "/" || is_digit(chr) ||
                       is_alpha(chr) || chr == "_") begin
            sline_nxt = line_r;
            scol_nxt  = col_r;
            soff_nxt  = off_r;
            len_nxt   = LEN_BITS'(1);
            if (chr == "/") begin
              mode_nxt = M_SLASH;
            end else if (is_digit(chr)) begin
              mode_nxt = (chr == "0") ? M_ZERO : M_DEC;
            end else if (is_alpha(chr) || chr == "_") begin
              mode_nxt = M_IDENT;
              cand_nxt = narrow(KW_ALL, chr, '0);
            end else begin
              mode_nxt = M_OP;
              pend_nxt = chr;
            end
          end else begin
            push.b_vld = 1'b1;
            push.b     = '{kind: K_ERR, line: line_r, col: col_r, off: off_r,
                           len: LEN_BITS'(1), bad: chr, last: 1'b0};
          end
        end

        // position counters
        if (adv) begin
          off_nxt = off_r + OFFSET_BITS'(1);
          if (chr == 8'h0A) begin
            line_nxt = (line_r == LINE_MAX) ? line_r : line_r + LINE_BITS'(1);
            col_nxt  = COLUMN_BITS'(1);
          end else begin
            col_nxt = (col_r == COL_MAX) ? col_r : col_r + COLUMN_BITS'(1);
          end
        end
      end
    end

    // last token of this request
    push.a.last = !push.b_vld;
    push.b.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pend_r  <= 8'd0;
      cand_r  <= KW_ALL;
      line_r  <= LINE_BITS'(1);
      col_r   <= COLUMN_BITS'(1);
      off_r   <= '0;
      sline_r <= LINE_BITS'(1);
      scol_r  <= COLUMN_BITS'(1);
      soff_r  <= '0;
      len_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      cand_r  <= cand_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      off_r   <= off_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      soff_r  <= soff_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== hdl/ctok_queue.sv =====
// Four-entry token queue: takes up to two tokens a cycle, hands out one unless out_stall holds it.
`timescale 1ns / 1ps

module ctok_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  ctok_pkg::push_t push,
  output logic            room,
  output logic            out_vld,
  input  logic            out_stall,
  output ctok_pkg::tok_t  head
);
  import ctok_pkg::*;

  tok_t       q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r,    cnt_nxt;

  logic       pop;
  logic [1:0] n_push;
  tok_t       first;

  // Two free entries are needed before a request may proceed
  assign room    = (cnt_r <= 3'd2);
  assign out_vld = (cnt_r != 3'd0);
  assign head    = q_r[rd_ptr_r];
  assign pop     = out_vld && !out_stall;
  assign n_push  = 2'(push.a_vld) + 2'(push.b_vld);
  assign first   = push.a_vld ? push.a : push.b;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    cnt_nxt    = cnt_r + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Token storage, compacted so that a lone token takes one entry
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= first;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= push.b;
    end
  end

endmodule

// ===== hdl/c_like_source_tokenizer.sv =====
// Top level of the streaming tokenizer for a small C-like language.
//
//   channel | direction | fields                                          | handshake
//   in_     | input     | opcode, char_byte                               | in_valid / in_stall
//   out_    | output    | token_kind, start_line, start_column,           | out_valid / out_stall
//           |           | start_offset, token_length, bad_char, last_of_run |
//
// One request is taken every cycle while the token queue has room. A request is
// scanned in the cycle after acceptance when the queue has room, else it waits in
// the input register; its tokens then go to the token queue, which drives the output.
// A request that closes one token and forms another yields two tokens; these
// leave one at a time from a four-entry token queue, and a held request stalls
// the input while the queue holds more than two tokens.
// rst_n is synchronous: scan state and counters return to line 1, column 1.
// out_stall holds the head token in place; upstream requests wait in the input register.
`timescale 1ns / 1ps

module c_like_source_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [7:0]                       in_char_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ctok_pkg::KIND_BITS-1:0]   out_token_kind,
  output logic [ctok_pkg::LINE_BITS-1:0]   out_start_line,
  output logic [ctok_pkg::COLUMN_BITS-1:0] out_start_column,
  output logic [ctok_pkg::OFFSET_BITS-1:0] out_start_offset,
  output logic [ctok_pkg::LEN_BITS-1:0]    out_token_length,
  output logic [7:0]                       out_bad_char,
  output logic                             out_last_of_run
);
  import ctok_pkg::*;

  logic       in_vld_r, in_vld_nxt;
  logic       in_op_r;
  logic [7:0] in_chr_r;
  logic       room;
  logic       go;
  logic       in_acc;
  push_t      push;
  tok_t       head;

  // Input register
  assign go       = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r  <= in_opcode;
      in_chr_r <= in_char_byte;
    end
  end

  // Scanner
  ctok_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .opcode (in_op_r),
    .chr    (in_chr_r),
    .push   (push)
  );

  // Token queue
  ctok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_start_line   = head.line;
  assign out_start_column = head.col;
  assign out_start_offset = head.off;
  assign out_token_length = head.len;
  assign out_bad_char     = head.bad;
  assign out_last_of_run  = head.last;

endmodule

// ===== hdl/ctok_checker.sv =====
// Port-level checks on the tokenizer output, bound to the top level.
`timescale 1ns / 1ps

module ctok_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [ctok_pkg::KIND_BITS-1:0]   out_token_kind,
  input logic [ctok_pkg::LEN_BITS-1:0]    out_token_length,
  input logic [7:0]                       out_bad_char,
  input logic                             out_last_of_run
);
  import ctok_pkg::*;

  // A stalled token stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
                               $stable(out_token_length) && $stable(out_bad_char))
    else $error("stalled token changed");

  // End of file always closes its run and has no length
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_EOF |-> out_last_of_run && out_token_length == '0)
    else $error("end-of-file token malformed");

  // Error tokens are one byte long; only they carry a byte
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == K_ERR |-> out_token_length == LEN_BITS'(1))
    else $error("error token length not one");

  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != K_ERR |-> out_bad_char == 8'd0)
    else $error("bad byte on a non-error token");

  // Every real token spans at least one byte
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != K_EOF |-> out_token_length != '0)
    else $error("zero-length token");

endmodule

bind c_like_source_tokenizer ctok_checker u_ctok_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_token_kind   (out_token_kind),
  .out_token_length (out_token_length),
  .out_bad_char     (out_bad_char),
  .out_last_of_run  (out_last_of_run)
);
